>>> rtl/count_sketch_2d_accumulator_top_assert.svh
// Assertion macros used by the checker file.
`ifndef COUNT_SKETCH_2D_ACCUMULATOR_TOP_ASSERT_SVH
`define COUNT_SKETCH_2D_ACCUMULATOR_TOP_ASSERT_SVH
// Implication checked every clock while reset is low.
`define CSA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked every clock while reset is low.
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> rtl/csa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_pkg
// Shared types and constants of the count sketch accumulator.
// ----------------------------------------------------------------------------
package csa_pkg;

   localparam logic [1:0] CMD_ACCUM = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_GROUP = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_SAT   = 2'd3;

   localparam logic [2:0] REG_ROWS      = 3'd0;
   localparam logic [2:0] REG_COLS      = 3'd1;
   localparam logic [2:0] REG_ROW_BSEED = 3'd2;
   localparam logic [2:0] REG_ROW_SSEED = 3'd3;
   localparam logic [2:0] REG_COL_BSEED = 3'd4;
   localparam logic [2:0] REG_COL_SSEED = 3'd5;
   localparam logic [2:0] REG_NETTING   = 3'd6;
   localparam logic [2:0] REG_GROUPS    = 3'd7;

   localparam int OUT_WIDTH = 48;

   localparam logic [63:0] MIX_ADD  = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        row_key;
      logic [31:0]        col_key;
      logic signed [31:0] element_value;
      logic [5:0]         read_row;
      logic [5:0]         read_col;
   } req_type;

   typedef struct packed {
      logic signed [47:0] cell_value;
      logic [1:0]         status;
   } rsp_type;

   // Hash unit handshake bundle.
   typedef struct packed {
      logic        start;
      logic [63:0] key;
   } hash_req_type;

endpackage

>>> rtl/csa_mix64.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_mix64
// Multi-cycle splitmix64 finalizer; each 64x64 product is built from 16x64
// partial products, one per cycle.
// ----------------------------------------------------------------------------
module csa_mix64
   import csa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_req_type hreq,
   output logic         done,
   output logic [63:0]  hash
);

   logic [63:0] z_ff, z_in;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  part_ff, part_in;
   logic        phase_ff, phase_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] mul_const;
   logic [15:0] mul_slice;
   logic [63:0] prod;

   assign mul_const = phase_ff ? MIX_MUL2 : MIX_MUL1;

   // Pick the 16-bit slice of the operand for this partial product.
   always_comb begin
      case (part_ff)
         2'd0:    mul_slice = z_ff[15:0];
         2'd1:    mul_slice = z_ff[31:16];
         2'd2:    mul_slice = z_ff[47:32];
         default: mul_slice = z_ff[63:48];
      endcase
   end

   assign prod = 64'(mul_const * 64'(mul_slice)) << {part_ff, 4'd0};

   // Sequence the seeding add and xor-shift, the two multiplies and the xor-shift after each.
   always_comb begin
      z_in     = z_ff;
      acc_in   = acc_ff;
      part_in  = part_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (hreq.start) begin
         z_in     = (hreq.key + MIX_ADD) ^ ((hreq.key + MIX_ADD) >> 30);
         acc_in   = '0;
         part_in  = '0;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in  = acc_ff + prod;
         part_in = part_ff + 2'd1;
         if (part_ff == 2'd3) begin
            acc_in = '0;
            if (phase_ff) begin
               z_in    = (acc_ff + prod) ^ ((acc_ff + prod) >> 31);
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               z_in     = (acc_ff + prod) ^ ((acc_ff + prod) >> 27);
               phase_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      z_ff     <= z_in;
      acc_ff   <= acc_in;
      part_ff  <= part_in;
      phase_ff <= phase_in;
   end

   assign done = done_ff;
   assign hash = z_ff;

endmodule

>>> rtl/csa_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_mod
// Restoring remainder of a 64-bit hash by a small size, one bit per cycle.
// ----------------------------------------------------------------------------
module csa_mod
   import csa_pkg::*;
#(
   parameter int SW = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [SW-1:0] divisor,
   output logic          done,
   output logic [SW-1:0] remainder
);

   logic [63:0]   shift_ff, shift_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW:0]   trial;

   assign trial = {rem_ff, shift_ff[63]};

   // One quotient bit per cycle, the partial remainder stays below the divisor.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = (trial >= {1'b0, divisor}) ? SW'(trial - {1'b0, divisor}) : SW'(trial);
         cnt_in   = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/count_sketch_2d_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// count_sketch_2d_accumulator_top
// Two-dimensional count sketch with splitmix64 bucket and sign hashing.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfer is taken when req_start is high and busy is low. The
//   payload req_data carries the command, keys, element value and read address.
//   Exactly one result per command appears on rsp_data for one cycle with
//   rsp_valid; the receiver cannot stall it. The user must write configuration
//   through csr_we / csr_index / csr_wdata while idle; the block does not check.
// Sequence (from the transfer to the result strobe):
//   Accumulate runs four hashes on one shared splitmix64 unit, two remainders
//   on a bit-serial divider, then a read-modify-write of the cell memory. A
//   read passes the registered memory read and a wait state; a rejected or
//   unused command goes straight to the result; a clear sets its result at
//   the transfer. Commands run one at a time: the next transfer is taken the
//   cycle the result shows, except after a clear, which then sweeps all
//   MAX_ROWS*MAX_COLS cells (4096 by default) one entry a cycle with busy high.
// Reset:
//   Control and configuration registers reset, and the memory is swept to zero.
// ----------------------------------------------------------------------------
module count_sketch_2d_accumulator_top
   import csa_pkg::*;
#(
   parameter int MAX_ROWS   = 64,
   parameter int MAX_COLS   = 64,
   parameter int CELL_WIDTH = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   input  req_type     req_data,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = RW + CW;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int SW    = 11;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_HASH   = 4'd2;
   localparam logic [3:0] S_HWAIT  = 4'd3;
   localparam logic [3:0] S_MODR   = 4'd4;
   localparam logic [3:0] S_MODC   = 4'd5;
   localparam logic [3:0] S_RD     = 4'd6;
   localparam logic [3:0] S_RMW    = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;
   localparam logic [3:0] S_WAIT   = 4'd9;

   localparam logic signed [CELL_WIDTH-1:0] CELL_HI = {1'b0, {(CELL_WIDTH-1){1'b1}}};
   localparam logic signed [CELL_WIDTH-1:0] CELL_LO = {1'b1, {(CELL_WIDTH-1){1'b0}}};

   // Configuration registers.
   logic [6:0]  rows_reg_ff, cols_reg_ff;
   logic [63:0] rbs_ff, rss_ff, cbs_ff, css_ff;
   logic        net_ff;
   logic [31:0] groups_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= 7'd64;
         cols_reg_ff <= 7'd64;
         rbs_ff      <= '0;
         rss_ff      <= '0;
         cbs_ff      <= '0;
         css_ff      <= '0;
         net_ff      <= 1'b0;
         groups_ff   <= 32'd1;
      end else if (csr_we) begin
         case (csr_index)
            REG_ROWS:      rows_reg_ff <= csr_wdata[6:0];
            REG_COLS:      cols_reg_ff <= csr_wdata[6:0];
            REG_ROW_BSEED: rbs_ff      <= csr_wdata;
            REG_ROW_SSEED: rss_ff      <= csr_wdata;
            REG_COL_BSEED: cbs_ff      <= csr_wdata;
            REG_COL_SSEED: css_ff      <= csr_wdata;
            REG_NETTING:   net_ff      <= csr_wdata[0];
            REG_GROUPS:    groups_ff   <= csr_wdata[31:0];
            default:       ;
         endcase
      end
   end

   // Sizes in use, clamped to 1..MAX.
   logic [SW-1:0] rows_use, cols_use;
   always_comb begin
      if (rows_reg_ff == 7'd0)                  rows_use = SW'(1);
      else if (SW'(rows_reg_ff) > SW'(MAX_ROWS)) rows_use = SW'(MAX_ROWS);
      else                                       rows_use = SW'(rows_reg_ff);
      if (cols_reg_ff == 7'd0)                  cols_use = SW'(1);
      else if (SW'(cols_reg_ff) > SW'(MAX_COLS)) cols_use = SW'(MAX_COLS);
      else                                       cols_use = SW'(cols_reg_ff);
   end

   // Control state.
   logic [3:0]  state_ff, state_in;
   logic [1:0]  hsel_ff, hsel_in;
   req_type     req_ff, req_in;
   logic [63:0] hrow_ff, hrow_in, hcol_ff, hcol_in;
   logic        srow_ff, srow_in, scol_ff, scol_in;
   logic [RW-1:0] rb_ff, rb_in;
   logic [CW-1:0] cb_ff, cb_in;
   logic [AW:0]   clr_ff, clr_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rspv_ff, rspv_in;

   // Cell memory with registered read.
   logic [CELL_WIDTH-1:0] mem [DEPTH];
   logic [CELL_WIDTH-1:0] rdata_ff;
   logic [AW-1:0]         raddr, waddr;
   logic                  we;
   logic [CELL_WIDTH-1:0] wdata;
   logic [AW-1:0]         cell_addr;

   // Cells are stored row by row, MAX_COLS entries per row.
   assign cell_addr = AW'(int'(rb_ff) * MAX_COLS + int'(cb_ff));

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   // Shared hash unit.
   hash_req_type hreq;
   logic         hdone;
   logic [63:0]  hval;

   csa_mix64 u_mix (
      .clock (clock),
      .reset (reset),
      .hreq  (hreq),
      .done  (hdone),
      .hash  (hval)
   );

   // Shared remainder unit.
   logic          mstart, mdone;
   logic [63:0]   mdiv;
   logic [SW-1:0] msize, mrem;

   csa_mod #(.SW(SW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mstart),
      .dividend  (mdiv),
      .divisor   (msize),
      .done      (mdone),
      .remainder (mrem)
   );

   // Saturating add of the signed delta.
   logic signed [CELL_WIDTH-1:0] cur, delta, sum;
   logic signed [CELL_WIDTH:0]   wide;
   logic                         sat;
   always_comb begin
      cur   = $signed(rdata_ff);
      delta = (srow_ff == scol_ff) ? CELL_WIDTH'(req_ff.element_value)
                                   : -CELL_WIDTH'(req_ff.element_value);
      wide  = {cur[CELL_WIDTH-1], cur} + {delta[CELL_WIDTH-1], delta};
      sat   = (wide[CELL_WIDTH] != wide[CELL_WIDTH-1]);
      if (!sat)                  sum = wide[CELL_WIDTH-1:0];
      else if (wide[CELL_WIDTH]) sum = CELL_LO;
      else                       sum = CELL_HI;
   end

   // Read value clamped to 48 bits.
   logic signed [OUT_WIDTH-1:0] rd_out;
   always_comb begin
      if (CELL_WIDTH > OUT_WIDTH) begin
         if (cur > $signed(CELL_WIDTH'({1'b0, {(OUT_WIDTH-1){1'b1}}})))
            rd_out = {1'b0, {(OUT_WIDTH-1){1'b1}}};
         else if (cur < -$signed(CELL_WIDTH'({1'b0, {(OUT_WIDTH-1){1'b1}}})) - 1)
            rd_out = {1'b1, {(OUT_WIDTH-1){1'b0}}};
         else
            rd_out = OUT_WIDTH'(cur);
      end else begin
         rd_out = OUT_WIDTH'(cur);
      end
   end

   logic [63:0] hash_key;
   always_comb begin
      case (hsel_ff)
         2'd0:    hash_key = rbs_ff ^ 64'(req_ff.row_key);
         2'd1:    hash_key = rss_ff ^ 64'(req_ff.row_key);
         2'd2:    hash_key = cbs_ff ^ 64'(req_ff.col_key);
         default: hash_key = css_ff ^ 64'(req_ff.col_key);
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      hsel_in  = hsel_ff;
      req_in   = req_ff;
      hrow_in  = hrow_ff;
      hcol_in  = hcol_ff;
      srow_in  = srow_ff;
      scol_in  = scol_ff;
      rb_in    = rb_ff;
      cb_in    = cb_ff;
      clr_in   = clr_ff;
      rsp_in   = rsp_ff;
      rspv_in  = 1'b0;
      hreq     = '{start: 1'b0, key: hash_key};
      mstart   = 1'b0;
      mdiv     = hrow_ff;
      msize    = rows_use;
      raddr    = cell_addr;
      waddr    = cell_addr;
      we       = 1'b0;
      wdata    = sum;
      case (state_ff)
         S_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff[AW-1:0];
            wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(DEPTH - 1)) begin
               state_in = S_IDLE;
               if (req_ff.command == CMD_CLEAR && rsp_ff.status == ST_OK) rspv_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_start) begin
               req_in = req_data;
               rsp_in = '{cell_value: '0, status: ST_OK};
               case (req_data.command)
                  CMD_ACCUM: begin
                     if (net_ff && req_data.row_key >= groups_ff) begin
                        rsp_in.status = ST_GROUP;
                        state_in = S_RESP;
                     end else begin
                        hsel_in  = 2'd0;
                        state_in = S_HASH;
                     end
                  end
                  CMD_READ: begin
                     if (SW'(req_data.read_row) >= rows_use ||
                         SW'(req_data.read_col) >= cols_use) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        rb_in = RW'(req_data.read_row);
                        cb_in = CW'(req_data.read_col);
                        state_in = S_RD;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     rspv_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_HASH: begin
            hreq.start = 1'b1;
            state_in   = S_HWAIT;
         end
         S_HWAIT: begin
            if (hdone) begin
               case (hsel_ff)
                  2'd0:    hrow_in = hval;
                  2'd1:    srow_in = hval[0];
                  2'd2:    hcol_in = hval;
                  default: scol_in = hval[0];
               endcase
               hsel_in = hsel_ff + 2'd1;
               if (hsel_ff == 2'd3) begin
                  mstart   = 1'b1;
                  state_in = S_MODR;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_MODR: begin
            if (mdone) begin
               rb_in    = RW'(mrem);
               mstart   = 1'b1;
               mdiv     = hcol_ff;
               msize    = cols_use;
               state_in = S_MODC;
            end
         end
         S_MODC: begin
            msize = cols_use;
            mdiv  = hcol_ff;
            if (mdone) begin
               cb_in    = CW'(mrem);
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = (req_ff.command == CMD_READ) ? S_RESP : S_RMW;
            if (req_ff.command == CMD_READ) state_in = S_WAIT;
         end
         S_WAIT: begin
            rsp_in.cell_value = rd_out;
            state_in = S_RESP;
         end
         S_RMW: begin
            we = 1'b1;
            if (sat) rsp_in.status = ST_SAT;
            state_in = S_RESP;
         end
         S_RESP: begin
            rspv_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rspv_ff  <= 1'b0;
         req_ff   <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rspv_ff  <= rspv_in;
         req_ff   <= req_in;
         rsp_ff   <= rsp_in;
      end
      hsel_ff <= hsel_in;
      hrow_ff <= hrow_in;
      hcol_ff <= hcol_in;
      srow_ff <= srow_in;
      scol_ff <= scol_in;
      rb_ff   <= rb_in;
      cb_ff   <= cb_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/csa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_checker
// Port-level checks of the count sketch accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "count_sketch_2d_accumulator_top_assert.svh"

module csa_checker
   import csa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_start,
   input logic        busy,
   input logic        rsp_valid,
   input rsp_type     rsp_data
);

   // A transfer in makes the block busy on the next cycle.
   `CSA_ASSERT_NEXT(a_take_busy, clock, reset, req_start && !busy, busy, "accepted item not busy")
   // Status 2 never carries a cell value.
   `CSA_ASSERT_IMP(a_range_zero, clock, reset, rsp_valid && rsp_data.status == ST_RANGE, rsp_data.cell_value == '0, "range error with data")
   // Rejected and saturated accumulates never carry a cell value.
   `CSA_ASSERT_IMP(a_accum_zero, clock, reset, rsp_valid && (rsp_data.status == ST_GROUP || rsp_data.status == ST_SAT), rsp_data.cell_value == '0, "accumulate result with data")

endmodule

bind count_sketch_2d_accumulator_top csa_checker u_csa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_start (req_start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
